FILE: rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants for the triangle plane contour block
// Holds the coordinate and distance widths and the front-to-back job record.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DistW  = 66;
  localparam int unsigned FracW  = 24;
  localparam int unsigned SegW   = 16;

  typedef enum logic [1:0] {
    ReadA = 2'd0,
    ReadB = 2'd1,
    ReadC = 2'd2
  } rd_state_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vtx_t;

  typedef struct packed {
    vtx_t v0;
    vtx_t v1;
    vtx_t v2;
    logic last;
  } job_t;

endpackage

FILE: rtl/tpc_front.sv
// ----------------------------------------------------------------------------
// tpc_front: request intake and vertex store
// Writes vertices, reads three corners per triangle and queues a job.
// ----------------------------------------------------------------------------
module tpc_front #(
  parameter int unsigned VERTEX_DEPTH = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [11:0]   in_slot,
  input  tpc_pkg::vtx_t in_coord,
  input  logic [11:0]   in_ca,
  input  logic [11:0]   in_cb,
  input  logic [11:0]   in_cc,
  input  logic          in_last,
  output logic          job_valid,
  input  logic          job_ready,
  output tpc_pkg::job_t job
);
  import tpc_pkg::*;

  localparam int unsigned AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

  vtx_t       mem [VERTEX_DEPTH];
  vtx_t       rd_q;
  rd_state_t  st_r, st_nxt;
  logic       busy_r, busy_nxt;
  logic [11:0] cb_r, cc_r;
  logic       last_r;
  logic       oor_q;
  vtx_t       v0_r, v1_r;
  logic       acc, wr_en, rd_en;
  logic [11:0] rd_idx;
  logic       job_v_r;
  job_t       job_r;
  logic       idx_ok;
  logic       job_load;

  // reads one per cycle: A at accept, B and C after
  assign in_ready = !busy_r && (!job_v_r || job_ready);
  assign acc      = in_valid && in_ready;
  assign wr_en    = acc && !in_op && ({20'd0, in_slot} < 32'(VERTEX_DEPTH));
  assign job_load = busy_r && st_r == ReadC && (!job_v_r || job_ready);

  always_comb begin
    rd_idx = in_ca;
    if (busy_r && st_r == ReadA) rd_idx = cb_r;
    else if (busy_r && st_r == ReadB) rd_idx = cc_r;
    // no read in ReadC: C data must hold while the job slot is full
    rd_en  = (acc && in_op) || (busy_r && st_r != ReadC);
    idx_ok = ({20'd0, rd_idx} < 32'(VERTEX_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(in_slot)] <= in_coord;
    if (rd_en && idx_ok) rd_q <= mem[AW'(rd_idx)];
    if (rd_en) oor_q <= !idx_ok;
  end

  // busy phase ReadA: A data arriving; ReadB: B arriving; ReadC: C arriving
  always_comb begin
    st_nxt   = st_r;
    busy_nxt = busy_r;
    if (acc && in_op) begin
      busy_nxt = 1'b1;
      st_nxt   = ReadA;
    end else if (busy_r) begin
      unique case (st_r)
        ReadA:   st_nxt = ReadB;
        ReadB:   st_nxt = ReadC;
        ReadC:   if (!job_v_r || job_ready) busy_nxt = 1'b0;
        default: st_nxt = ReadA;
      endcase
    end
  end

  vtx_t rd_v;
  assign rd_v = oor_q ? '0 : rd_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ReadA;
      busy_r  <= 1'b0;
      job_v_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      busy_r <= busy_nxt;
      if (job_load) job_v_r <= 1'b1;
      else if (job_ready) job_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_op) begin
      cb_r   <= in_cb;
      cc_r   <= in_cc;
      last_r <= in_last;
    end
    if (busy_r && st_r == ReadA) v0_r <= rd_v;
    if (busy_r && st_r == ReadB) v1_r <= rd_v;
    if (job_load) begin
      job_r.v0   <= v0_r;
      job_r.v1   <= v1_r;
      job_r.v2   <= rd_v;
      job_r.last <= last_r;
    end
  end

  // hold ReadC while the job slot is full
  assign job_valid = job_v_r;
  assign job       = job_r;
endmodule

FILE: rtl/tpc_back.sv
// ----------------------------------------------------------------------------
// tpc_back: edge crossing engine
// Per triangle: distances, up to three serial divisions, interpolation, dedup.
// ----------------------------------------------------------------------------
module tpc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] nx,
  input  logic signed [31:0] ny,
  input  logic signed [31:0] nz,
  input  logic signed [31:0] off,
  input  logic               job_valid,
  output logic               job_ready,
  input  tpc_pkg::job_t      job,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [207:0]       out_tdata
);
  import tpc_pkg::*;

  // step codes
  typedef enum logic [3:0] {
    SIdle, SProd, SDist, SEdge, SDiv, SMul, SAdd, SNext, SDone
  } bk_state_t;

  bk_state_t st_r, st_nxt;
  job_t      j_r;
  logic [1:0] cnt_r;       // product/dist vertex, and edge index
  logic signed [63:0] px_r, py_r, pz_r;
  logic signed [DistW-1:0] d_r [3];
  logic [4:0]  it_r;
  logic [65:0] den_r, rem_r;
  logic [24:0] q_r;
  logic signed [58:0] m_r [3];
  vtx_t        pts_r [3];
  logic [1:0]  found_r;
  logic [SegW-1:0] seg_r;
  logic        ov_r;
  logic [207:0] od_r;
  logic        busy_r;

  vtx_t va, vb, vsel;
  logic [1:0] eb;
  logic signed [DistW-1:0] da, db;
  assign eb = (cnt_r == 2'd2) ? 2'd0 : cnt_r + 2'd1;

  function automatic vtx_t pick(job_t jj, logic [1:0] i);
    unique case (i)
      2'd0:    pick = jj.v0;
      2'd1:    pick = jj.v1;
      default: pick = jj.v2;
    endcase
  endfunction

  assign va   = pick(j_r, cnt_r);
  assign vb   = pick(j_r, eb);
  assign vsel = va;
  assign da   = d_r[cnt_r];
  assign db   = d_r[eb];

  logic skip;
  assign skip = (da == db) || (da > 0 && db > 0) || (da < 0 && db < 0);

  logic [65:0] ua, ub;
  assign ua = da[DistW-1] ? 66'(-da) : 66'(da);
  assign ub = db[DistW-1] ? 66'(-db) : 66'(db);

  logic [66:0] rsh;
  assign rsh = {rem_r, 1'b0};

  logic signed [32:0] df [3];
  assign df[0] = 33'(vb.x) - 33'(va.x);
  assign df[1] = 33'(vb.y) - 33'(va.y);
  assign df[2] = 33'(vb.z) - 33'(va.z);

  vtx_t p;
  always_comb begin
    p.x = 32'(m_r[0] >>> FracW) + va.x;
    p.y = 32'(m_r[1] >>> FracW) + va.y;
    p.z = 32'(m_r[2] >>> FracW) + va.z;
  end

  logic dup;
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < 3; i++)
      if (2'(i) < found_r && pts_r[i] == p) dup = 1'b1;
  end

  logic done_go;
  assign done_go = (st_r == SDone) && (!ov_r || out_tready);

  assign job_ready = !busy_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      SIdle: if (job_valid) st_nxt = SProd;
      SProd: st_nxt = SDist;
      SDist: st_nxt = (cnt_r == 2'd2) ? SEdge : SProd;
      SEdge: st_nxt = skip ? SNext : SDiv;
      SDiv:  if (it_r == 5'd23) st_nxt = SMul;
      SMul:  st_nxt = SAdd;
      SAdd:  st_nxt = SNext;
      SNext: st_nxt = (cnt_r == 2'd2) ? SDone : SEdge;
      SDone: if (!ov_r || out_tready) st_nxt = SIdle;
      default: st_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SIdle;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      seg_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (done_go && found_r == 2'd2) ov_r <= 1'b1;
      else if (ov_r && out_tready) ov_r <= 1'b0;
      if (st_r == SIdle && job_valid) busy_r <= 1'b1;
      else if (done_go) busy_r <= 1'b0;
      if (done_go) begin
        if (j_r.last) seg_r <= '0;
        else if (found_r == 2'd2 && seg_r != '1) seg_r <= seg_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      SIdle: begin
        j_r     <= job;
        cnt_r   <= 2'd0;
        found_r <= 2'd0;
      end
      SProd: begin
        px_r <= 64'(vsel.x) * 64'(nx);
        py_r <= 64'(vsel.y) * 64'(ny);
        pz_r <= 64'(vsel.z) * 64'(nz);
      end
      SDist: begin
        d_r[cnt_r] <= DistW'(px_r >>> 16) + DistW'(py_r >>> 16)
                    + DistW'(pz_r >>> 16) - DistW'(off);
        cnt_r <= (cnt_r == 2'd2) ? 2'd0 : cnt_r + 2'd1;
      end
      SEdge: begin
        den_r <= ua + ub;
        rem_r <= ua;
        q_r   <= '0;
        it_r  <= 5'd0;
        // first step: ua >= ua+ub only when ub is 0
        if (ua >= ua + ub) begin
          q_r   <= 25'd1;
          rem_r <= ua - (ua + ub);
        end
      end
      SDiv: begin
        if (rsh >= {1'b0, den_r}) begin
          rem_r <= 66'(rsh - {1'b0, den_r});
          q_r   <= {q_r[23:0], 1'b1};
        end else begin
          rem_r <= rsh[65:0];
          q_r   <= {q_r[23:0], 1'b0};
        end
        it_r <= it_r + 5'd1;
      end
      SMul: begin
        for (int k = 0; k < 3; k++) m_r[k] <= 59'(signed'({1'b0, q_r})) * 59'(df[k]);
      end
      SAdd: begin
        if (!dup && found_r < 2'd3) begin
          pts_r[found_r] <= p;
          found_r <= found_r + 2'd1;
        end
      end
      SNext: cnt_r <= cnt_r + 2'd1;
      SDone: begin
        if ((!ov_r || out_tready) && found_r == 2'd2)
          od_r <= {seg_r, pts_r[1].z, pts_r[1].y, pts_r[1].x,
                   pts_r[0].z, pts_r[0].y, pts_r[0].x};
      end
      default: ;
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule

FILE: rtl/triangle_plane_contour.sv
// ----------------------------------------------------------------------------
// triangle_plane_contour: slices triangles with a configured plane
// Channel  Dir  Request
// in_      in   vertex write or triangle (tdata, tuser = operation)
// out_     out  one segment per triangle with two distinct crossings
// cfg_     in   plane normal and offset, write only
// A vertex write needs no busy phase; a triangle holds the input through its accept
// and the ReadA, ReadB and ReadC states, longer while the one-entry job slot is full.
// The back takes one triangle at a time, runs a serial divider for each crossing
// edge and passes over skipped edges, and waits while its output is full.
// Reset is synchronous; the vertex store needs no clearing.
// ----------------------------------------------------------------------------
module triangle_plane_contour #(
  parameter int unsigned VERTEX_DEPTH = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // slot[11:0], x[43:12], y[75:44], z[107:76], a[119:108], b[131:120], c[143:132]
  input  logic [143:0] in_tdata,
  input  logic         in_tuser,   // operation
  input  logic         in_tlast,   // last_triangle
  output logic         out_tvalid,
  input  logic         out_tready,
  // start xyz, end xyz, segment_number[207:192]
  output logic [207:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import tpc_pkg::*;

  typedef enum logic [1:0] {RegNx, RegNy, RegNz, RegOff} reg_idx_t;

  logic signed [31:0] nx_r, ny_r, nz_r, off_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= '0; ny_r <= '0; nz_r <= '0; off_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        RegNx:   nx_r  <= cfg_data;
        RegNy:   ny_r  <= cfg_data;
        RegNz:   nz_r  <= cfg_data;
        default: off_r <= cfg_data;
      endcase
    end
  end

  vtx_t c;
  assign c.x = in_tdata[43:12];
  assign c.y = in_tdata[75:44];
  assign c.z = in_tdata[107:76];

  logic jv, jr;
  job_t jb;

  tpc_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_op(in_tuser),
    .in_slot(in_tdata[11:0]), .in_coord(c),
    .in_ca(in_tdata[119:108]), .in_cb(in_tdata[131:120]), .in_cc(in_tdata[143:132]),
    .in_last(in_tlast), .job_valid(jv), .job_ready(jr), .job(jb)
  );

  tpc_back u_back (
    .clk, .rst_n, .nx(nx_r), .ny(ny_r), .nz(nz_r), .off(off_r),
    .job_valid(jv), .job_ready(jr), .job(jb),
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule

FILE: rtl/tpc_checker.sv
// ----------------------------------------------------------------------------
// tpc_checker: port-level checks for triangle_plane_contour
// Watches output hold behavior, reset and the segment number sequence.
// ----------------------------------------------------------------------------
module tpc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [207:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped while stalled");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready ##1 out_tvalid && out_tready |->
      out_tdata[207:192] == 16'd0 || out_tdata[207:192] == $past(out_tdata[207:192]) + 16'd1
      || out_tdata[207:192] == 16'hFFFF)
    else $error("segment number jump");
endmodule

bind triangle_plane_contour tpc_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);

FILE: tb/triangle_plane_contour_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_plane_contour_checker: segment predictor and scoreboard
// Watches the vertex/triangle, segment and register channels, keeps its own
// vertex copy, plane and segment counter, predicts each segment and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module triangle_plane_contour_checker #(
  parameter bit       OpVertex   = 1'b0,
  parameter bit       OpTriangle = 1'b1,
  parameter bit [1:0] RegNormX   = 2'd0,
  parameter bit [1:0] RegNormY   = 2'd1,
  parameter bit [1:0] RegNormZ   = 2'd2,
  parameter bit [1:0] RegOffset  = 2'd3
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [207:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           segment_total,
  output int           triangle_total
);

  typedef struct {
    int          sx, sy, sz, ex, ey, ez;
    bit [15:0]   num;
  } segment_t;

  int          vx [4096];
  int          vy [4096];
  int          vz [4096];
  int          nx, ny, nz, offs;
  bit [15:0]   seg_counter;
  segment_t    expected_segments[$];

  initial begin
    fail_count = 0;
    segment_total = 0;
    triangle_total = 0;
  end

  assign pending = expected_segments.size();

  function automatic longint plane_dist(int x, int y, int z);
    return ((longint'(x) * longint'(nx)) >>> 16) + ((longint'(y) * longint'(ny)) >>> 16)
         + ((longint'(z) * longint'(nz)) >>> 16) - longint'(offs);
  endfunction

  task automatic slice_triangle(input bit [11:0] ia, ib, ic, input bit last);
    int       cx [3];
    int       cy [3];
    int       cz [3];
    int       px [3];
    int       py [3];
    int       pz [3];
    int       found;
    int       q, r;
    longint   da, db, ua, ub, f;
    bit [87:0] num;
    int       p0, p1, p2;
    bit       dup;
    segment_t s;
    found = 0;
    cx[0] = vx[ia]; cy[0] = vy[ia]; cz[0] = vz[ia];
    cx[1] = vx[ib]; cy[1] = vy[ib]; cz[1] = vz[ib];
    cx[2] = vx[ic]; cy[2] = vy[ic]; cz[2] = vz[ic];
    for (int e = 0; e < 3; e++) begin
      q = e;
      r = (e + 1) % 3;
      da = plane_dist(cx[q], cy[q], cz[q]);
      db = plane_dist(cx[r], cy[r], cz[r]);
      if (da == db) continue;
      if ((da > 0 && db > 0) || (da < 0 && db < 0)) continue;
      ua = (da < 0) ? -da : da;
      ub = (db < 0) ? -db : db;
      num = {ua, 24'd0};
      f = longint'(num / (ua + ub));
      p0 = cx[q] + int'((f * (longint'(cx[r]) - cx[q])) >>> 24);
      p1 = cy[q] + int'((f * (longint'(cy[r]) - cy[q])) >>> 24);
      p2 = cz[q] + int'((f * (longint'(cz[r]) - cz[q])) >>> 24);
      dup = 0;
      for (int j = 0; j < found; j++)
        if (px[j] == p0 && py[j] == p1 && pz[j] == p2) dup = 1;
      if (!dup && found < 3) begin
        px[found] = p0; py[found] = p1; pz[found] = p2;
        found++;
      end
    end
    if (found == 2) begin
      s.sx = px[0]; s.sy = py[0]; s.sz = pz[0];
      s.ex = px[1]; s.ey = py[1]; s.ez = pz[1];
      s.num = seg_counter;
      expected_segments.push_back(s);
      if (seg_counter != 16'hFFFF) seg_counter++;
    end
    if (last) seg_counter = '0;
  endtask

  task automatic report(input string field, input longint got, input longint want);
    $display("%0t: segment %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    segment_t s;
    if (!rst_n) begin
      nx = 0; ny = 0; nz = 0; offs = 0;
      seg_counter = '0;
      expected_segments.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegNormX:  nx = cfg_data;
          RegNormY:  ny = cfg_data;
          RegNormZ:  nz = cfg_data;
          RegOffset: offs = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OpVertex) begin
          vx[in_tdata[11:0]] = in_tdata[43:12];
          vy[in_tdata[11:0]] = in_tdata[75:44];
          vz[in_tdata[11:0]] = in_tdata[107:76];
        end else begin
          triangle_total++;
          slice_triangle(in_tdata[119:108], in_tdata[131:120], in_tdata[143:132], in_tlast);
        end
      end
      if (out_tvalid && out_tready) begin
        segment_total++;
        if (expected_segments.size() == 0) begin
          $display("%0t: segment returned with none expected", $realtime);
          fail_count++;
        end else begin
          s = expected_segments.pop_front();
          if (int'(out_tdata[31:0])    != s.sx) report("start_x", int'(out_tdata[31:0]), s.sx);
          if (int'(out_tdata[63:32])   != s.sy) report("start_y", int'(out_tdata[63:32]), s.sy);
          if (int'(out_tdata[95:64])   != s.sz) report("start_z", int'(out_tdata[95:64]), s.sz);
          if (int'(out_tdata[127:96])  != s.ex) report("end_x", int'(out_tdata[127:96]), s.ex);
          if (int'(out_tdata[159:128]) != s.ey) report("end_y", int'(out_tdata[159:128]), s.ey);
          if (int'(out_tdata[191:160]) != s.ez) report("end_z", int'(out_tdata[191:160]), s.ez);
          if (out_tdata[207:192] != s.num) report("number", out_tdata[207:192], s.num);
        end
      end
    end
  end

endmodule

FILE: tb/triangle_plane_contour_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_plane_contour_test: stimulus and verdict for the contour block
// Loads vertices, slices triangles against several planes (zero, axis
// aligned, extreme and random) with random gaps and back-pressure; the
// checker predicts and compares every segment.
// ----------------------------------------------------------------------------
module triangle_plane_contour_test;

  localparam bit       OpVertex   = 1'b0;
  localparam bit       OpTriangle = 1'b1;
  localparam bit [1:0] RegNormX   = 2'd0;
  localparam bit [1:0] RegNormY   = 2'd1;
  localparam bit [1:0] RegNormZ   = 2'd2;
  localparam bit [1:0] RegOffset  = 2'd3;
  localparam int       DrainWait  = 300;
  localparam int       IdleLimit  = 5000;
  localparam int       Unity      = 32'h0001_0000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  // slot[11:0], x[43:12], y[75:44], z[107:76], a[119:108], b[131:120], c[143:132]
  logic [143:0] in_tdata = '0;
  logic         in_tuser = 0;   // operation
  logic         in_tlast = 0;   // last_triangle
  logic         out_tvalid;
  logic         out_tready = 0;
  // start xyz, end xyz, segment_number[207:192]
  logic [207:0] out_tdata;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  int fail_count, pending, segment_total, triangle_total;
  int idle_cycles = 0;
  bit busy_side = 1;   // 0: no gaps on either side
  bit written [4096];
  bit [11:0] written_slots[$];

  always #2 clk = ~clk;

  triangle_plane_contour dut (.*);

  triangle_plane_contour_checker #(
    .OpVertex(OpVertex), .OpTriangle(OpTriangle), .RegNormX(RegNormX),
    .RegNormY(RegNormY), .RegNormZ(RegNormZ), .RegOffset(RegOffset)
  ) checker_i (.*);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stall before each segment
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = busy_side ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send(input bit op, input bit [143:0] data, input bit last);
    int gap;
    gap = busy_side ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= data;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic put_vertex(input bit [11:0] slot, input int x, y, z, input bit last = 0);
    send(OpVertex, {36'd0, z, y, x, slot}, last);
    if (!written[slot]) begin
      written[slot] = 1;
      written_slots.push_back(slot);
    end
  endtask

  task automatic put_triangle(input bit [11:0] a, b, c, input bit last);
    send(OpTriangle, {c, b, a, 108'd0} | 144'($urandom) | (144'($urandom) << 32)
         | (144'($urandom) << 64) | (144'($urandom & 12'hFFF) << 96), last);
  endtask

  // write all four plane registers once the block has drained
  task automatic set_plane(input int a, b, c, d);
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    cfg_we <= 1; cfg_index <= RegNormX;  cfg_data <= a; @(posedge clk);
    cfg_index <= RegNormY;  cfg_data <= b; @(posedge clk);
    cfg_index <= RegNormZ;  cfg_data <= c; @(posedge clk);
    cfg_index <= RegOffset; cfg_data <= d; @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
      default: return $signed($urandom_range(0, 2 ** 25)) - 2 ** 24;
    endcase
  endfunction

  function automatic int rand_reg();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 0;
      default: return $signed($urandom_range(0, 2 ** 19)) - 2 ** 18;
    endcase
  endfunction

  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) busy_side = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 3)
        put_vertex($urandom_range(0, 4095), rand_coord(), rand_coord(), rand_coord(),
                   $urandom_range(0, 1));
      else
        put_triangle(written_slots[$urandom_range(0, written_slots.size() - 1)],
                     written_slots[$urandom_range(0, written_slots.size() - 1)],
                     written_slots[$urandom_range(0, written_slots.size() - 1)],
                     $urandom_range(0, 5) == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset plane has a zero normal: every distance is equal, no segments
    put_vertex(12'd0,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_vertex(12'hFFF,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    put_vertex(12'd1,    0, 0, 0);
    put_vertex(12'd2,    5, 5, -100);
    put_vertex(12'd3,    7, -7, 0);
    put_vertex(12'd4,    1, 2, 300);
    put_vertex(12'd6,    -9, 4, 0);
    put_vertex(12'hAAA,  32'hAAAA_AAAA, 32'h5555_5555, -Unity);
    put_vertex(12'h555,  32'h5555_5555, 32'hAAAA_AAAA, Unity);
    put_triangle(12'd0, 12'hFFF, 12'd2, 0);

    set_plane(0, 0, Unity, 0);
    put_triangle(12'd0, 12'hFFF, 12'd2, 0);    // plain crossing
    put_triangle(12'd1, 12'd3, 12'd4, 0);      // edge lying in the plane
    put_triangle(12'd1, 12'd0, 12'hFFF, 0);    // on-plane corner shared by the edges that meet it
    put_triangle(12'd1, 12'd1, 12'd1, 0);      // degenerate, nothing
    put_triangle(12'd0, 12'd0, 12'd4, 1);      // all above, ends batch
    put_triangle(12'd1, 12'd3, 12'd6, 0);      // whole triangle in plane
    put_triangle(12'hAAA, 12'h555, 12'd2, 1);
    put_triangle(12'h555, 12'hAAA, 12'd4, 0);

    set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    random_items(90);
    set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    random_items(90);
    for (int ph = 0; ph < 4; ph++) begin
      set_plane(rand_reg(), rand_reg(), rand_reg(), rand_reg());
      random_items(90);
    end

    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("covered %0d triangles giving %0d segments over zero, extreme and random planes",
             triangle_total, segment_total);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tpc_pkg.sv
rtl/tpc_front.sv
rtl/tpc_back.sv
rtl/triangle_plane_contour.sv
rtl/tpc_checker.sv
tb/triangle_plane_contour_checker.sv
tb/triangle_plane_contour_test.sv
